// ----- rtl/bi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver package
// Shared types, opcodes, status codes and register indexes of the block
// interleaver.
// ----------------------------------------------------------------------------
package bi_pkg;

	// configuration port
	localparam int CFG_W  = 9;
	localparam int IDX_W  = 2;
	// width of row_count * column_count
	localparam int SIZE_W = 18;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROWS    = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLS    = 2'd1;
	localparam logic [IDX_W-1:0] REG_REVERSE = 2'd2;

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_LOADED  = 2'd0;
	localparam logic [1:0] STAT_READ    = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUT
	} bi_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take;   // capture the incoming transaction
		logic exec;   // run the load or read on the store
		logic put;    // move the result into the output register
	} bi_cmd_t;

endpackage

// ----- rtl/bi_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver input channel
// Valid/ready channel carrying one load or read request.
// ----------------------------------------------------------------------------
interface bi_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// ----- rtl/bi_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bi_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_out;
	logic [1:0] status;

	modport source (output valid, output out_byte, output last_out, output status,
		input ready);
	modport sink   (input valid, input out_byte, input last_out, input status,
		output ready);
endinterface

// ----- rtl/bi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver controller
// Sequences each transaction: capture, store access, result hand-off.
// ----------------------------------------------------------------------------
module bi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	output bi_pkg::bi_cmd_t cmd
);
	import bi_pkg::*;

	bi_state_t state_q;
	bi_state_t state_nxt;
	logic      out_valid_q;
	logic      slot_free;

	// output register can take a new result this cycle
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_PUT;
			end
			ST_PUT: begin
				if (slot_free)
					state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_PUT: begin
				cmd.put = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.put)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_take_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted transaction not executed");
	a_exec_to_put: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> (state_q == ST_PUT))
		else $error("execute not followed by result hand-off");
	a_put_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("result hand-off lost");
	a_put_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PUT) && out_valid_q && !out_ready) |=> (state_q == ST_PUT))
		else $error("result overwritten while output stalled");
`endif

endmodule

// ----- rtl/bi_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver datapath
// Configuration registers, scatter and drain pointers, byte store and
// output register.
// ----------------------------------------------------------------------------
module bi_dp #(
	parameter int MAX_CELLS = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bi_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bi_pkg::CFG_W-1:0]    cfg_data,
	input  bi_pkg::bi_cmd_t             cmd,
	input  logic                        opcode,
	input  logic [7:0]                  data_byte,
	output logic [7:0]                  out_byte,
	output logic                        last_out,
	output logic [1:0]                  status
);
	import bi_pkg::*;

	localparam int AW = $clog2(MAX_CELLS);
	// pointers hold up to the block size, transient sums up to size + step
	localparam int PW = $clog2(MAX_CELLS + 1024);
	localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_CELLS);

	// configuration
	logic [CFG_W-1:0]  rows_q;
	logic [CFG_W-1:0]  cols_q;
	logic              rev_q;
	logic [SIZE_W-1:0] prod;
	logic [SIZE_W-1:0] size_q;
	logic              bad_q;

	// pointers and phase
	logic [PW-1:0] scatter_q;
	logic [PW-1:0] loaded_q;
	logic [PW-1:0] drain_q;
	logic          draining_q;

	// captured transaction and pending result
	logic       op_q;
	logic [7:0] data_q;
	logic [1:0] res_stat_q;
	logic       res_last_q;

	// store
	logic [7:0] mem [MAX_CELLS];
	logic [7:0] rd_q;

	// output register
	logic [7:0] out_byte_q;
	logic       last_out_q;
	logic [1:0] status_q;

	// execute-stage arithmetic
	logic [CW-1:0]    size_c;
	logic [CFG_W-1:0] step;
	logic [CW-1:0]    pos0;
	logic [CW-1:0]    sum;
	logic [CW-1:0]    nxt;
	logic [CW-1:0]    cnt1;
	logic             done;
	logic [CW-1:0]    idx;
	logic [CW-1:0]    idx1;
	logic             last;
	logic             refuse;
	logic             do_load;
	logic             do_read;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
			rev_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS:    rows_q <= cfg_data;
				REG_COLS:    cols_q <= cfg_data;
				REG_REVERSE: rev_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// block size and range check, registered after the multiply
	assign prod = SIZE_W'(rows_q) * SIZE_W'(cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
			bad_q  <= 1'b0;
		end else begin
			size_q <= prod;
			bad_q  <= (prod == '0) || (CW'(prod) > MAX_C);
		end
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= opcode;
			data_q <= data_byte;
		end
	end

	// scatter, count and drain arithmetic
	always_comb begin
		size_c = CW'(size_q);
		step   = rev_q ? cols_q : rows_q;
		pos0   = (CW'(scatter_q) >= size_c) ? '0 : CW'(scatter_q);
		sum    = pos0 + CW'(step);
		nxt    = (sum >= size_c) ? (sum + CW'(1) - size_c) : sum;
		cnt1   = CW'(loaded_q) + CW'(1);
		done   = (cnt1 >= size_c);
		idx    = (CW'(drain_q) >= size_c) ? (size_c - CW'(1)) : CW'(drain_q);
		idx1   = idx + CW'(1);
		last   = (idx1 == size_c);
		refuse = bad_q || ((op_q == OP_LOAD) && draining_q) ||
			((op_q == OP_READ) && !draining_q);
		do_load = cmd.exec && !refuse && (op_q == OP_LOAD);
		do_read = cmd.exec && !refuse && (op_q == OP_READ);
	end

	// pointer and phase update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scatter_q  <= '0;
			loaded_q   <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (do_load) begin
			if (done) begin
				scatter_q  <= '0;
				loaded_q   <= '0;
				drain_q    <= '0;
				draining_q <= 1'b1;
			end else begin
				scatter_q <= nxt[PW-1:0];
				loaded_q  <= cnt1[PW-1:0];
			end
		end else if (do_read) begin
			if (last) begin
				drain_q    <= '0;
				draining_q <= 1'b0;
			end else begin
				drain_q <= idx1[PW-1:0];
			end
		end
	end

	// byte store, at most one access per transaction
	always_ff @(posedge clk) begin
		if (do_load)
			mem[pos0[AW-1:0]] <= data_q;
		if (do_read)
			rd_q <= mem[idx[AW-1:0]];
	end

	// pending result status
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (refuse) begin
				res_stat_q <= STAT_REFUSED;
				res_last_q <= 1'b0;
			end else if (op_q == OP_LOAD) begin
				res_stat_q <= STAT_LOADED;
				res_last_q <= 1'b0;
			end else begin
				res_stat_q <= STAT_READ;
				res_last_q <= last;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_byte_q <= (res_stat_q == STAT_READ) ? rd_q : 8'd0;
			last_out_q <= res_last_q;
			status_q   <= res_stat_q;
		end
	end

	assign out_byte = out_byte_q;
	assign last_out = last_out_q;
	assign status   = status_q;

`ifndef SYNTHESIS
	a_refuse_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && refuse) |=> ($stable(scatter_q) && $stable(loaded_q) &&
		$stable(drain_q) && $stable(draining_q)))
		else $error("refused transaction changed pointer state");
	a_full_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_load && done) |=> (draining_q && (loaded_q == '0) && (drain_q == '0)))
		else $error("full buffer did not switch to draining");
	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(do_read && last) |=> (!draining_q && (drain_q == '0)))
		else $error("last byte did not return to loading");
`endif

endmodule

// ----- rtl/block_interleaver_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver top level
// Row-column byte interleaver with a single-port byte store.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready requests. opcode 0 loads data_byte at the current
//             scatter position, opcode 1 reads the next byte in store order.
//   results : one transaction per request: out_byte, last_out, status
//             (loaded, read, or refused for a wrong-phase request or an empty or oversize matrix).
//   cfg     : write enable, index (0 rows, 1 columns, 2 reverse), data; write
//             only while no request is in flight.
// Sequence: the controller steps through capture, store access (registered
//   read) and hand-off, and accepts a new request only once the last result
//   has been handed off to the output register.
// Reset: controller idle, pointers cleared, loading phase, registers back to
//   1 row, 1 column, forward mode. The store is not cleared.
// Stall: a result waits in the output register; one more request is accepted
//   and processed, then the controller holds until the output is taken.
// ----------------------------------------------------------------------------
module block_interleaver_top #(
	parameter int MAX_CELLS = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [bi_pkg::IDX_W-1:0] cfg_index,
	input  logic [bi_pkg::CFG_W-1:0] cfg_data,
	bi_in_if.sink                    items,
	bi_out_if.source                 results
);
	import bi_pkg::*;

	bi_cmd_t cmd;

	// sequencing
	bi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.cmd       (cmd)
	);

	// store and pointers
	bi_dp #(
		.MAX_CELLS (MAX_CELLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.opcode    (items.opcode),
		.data_byte (items.data_byte),
		.out_byte  (results.out_byte),
		.last_out  (results.last_out),
		.status    (results.status)
	);

endmodule

// ----- tb/sv/block_interleaver_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block interleaver testbench
// Drives load/read transactions and register writes into the row-column
// interleaver, predicts every result with an in-bench model of the scatter
// and drain pointers, and checks each result field by field, in order.
// A short directed table is walked first, then random full blocks with noise.
// ----------------------------------------------------------------------------
module block_interleaver_top_tb;
	import bi_pkg::*;

	localparam int STORE_CELLS = 65536;
	// index with no register behind it; writes to it are dropped
	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 400;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
		logic [1:0] status;
	} result_t;

	// one row of the directed table: a register write or a transaction
	typedef struct packed {
		logic             is_cfg;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		logic             op;
		logic [7:0]       din;
		logic             typed;
		result_t          want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bi_in_if  item_ch ();
	bi_out_if result_ch ();

	block_interleaver_top #(
		.MAX_CELLS(STORE_CELLS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.items    (item_ch),
		.results  (result_ch)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state: registers, pointers and the byte store
	logic [CFG_W-1:0] cfg_rows = 9'd1;
	logic [CFG_W-1:0] cfg_cols = 9'd1;
	logic             cfg_reverse = 1'b0;
	int               scatter_at = 0;
	int               fill_count = 0;
	int               drain_at = 0;
	logic             draining = 1'b0;
	logic [7:0]       cell_mem [0:STORE_CELLS-1];

	result_t   pending_results [$];
	plan_row_t plan [$];

	int err_count = 0;
	int n_items = 0;
	int n_results = 0;
	int n_refused = 0;
	int n_blocks = 0;
	int n_writes = 0;
	int random_count = 0;
	int send_calm = 0;
	int take_calm = 0;

	// expected result of one accepted transaction; advances the predictor
	function automatic result_t next_interleaver_result(logic op, logic [7:0] din);
		int size;
		int step;
		int idx;
		result_t r;
		size = int'(cfg_rows) * int'(cfg_cols);
		r = '{out_byte: 8'h00, last_out: 1'b0, status: STAT_REFUSED};
		if (size == 0 || size > STORE_CELLS)
			return r;
		if (op == OP_LOAD) begin
			if (draining)
				return r;
			step = cfg_reverse ? int'(cfg_cols) : int'(cfg_rows);
			// registers may have shrunk the matrix since the last load
			if (scatter_at >= size)
				scatter_at = 0;
			cell_mem[scatter_at] = din;
			scatter_at += step;
			if (scatter_at >= size)
				scatter_at -= size - 1;
			fill_count++;
			if (fill_count >= size) begin
				draining = 1'b1;
				drain_at = 0;
				scatter_at = 0;
				fill_count = 0;
			end
			r.status = STAT_LOADED;
			return r;
		end
		if (!draining)
			return r;
		// drain pointer saturates on the last cell if the matrix shrank
		idx = (drain_at >= size) ? size - 1 : drain_at;
		r.out_byte = cell_mem[idx];
		r.last_out = (idx == size - 1);
		r.status = STAT_READ;
		if (r.last_out) begin
			draining = 1'b0;
			drain_at = 0;
		end else begin
			drain_at = idx + 1;
		end
		return r;
	endfunction

	// wait draw: a random idle gap, with runs of back-to-back transactions
	function automatic int pick_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// table row builders
	function automatic plan_row_t cfg_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic plan_row_t load_row(logic [7:0] din);
		plan_row_t r;
		r = '0;
		r.op = OP_LOAD;
		r.din = din;
		return r;
	endfunction

	function automatic plan_row_t read_row();
		plan_row_t r;
		r = '0;
		r.op = OP_READ;
		return r;
	endfunction

	function automatic plan_row_t load_row_want(logic [7:0] din, logic [1:0] st);
		plan_row_t r;
		r = load_row(din);
		r.typed = 1'b1;
		r.want = '{out_byte: 8'h00, last_out: 1'b0, status: st};
		return r;
	endfunction

	function automatic plan_row_t read_row_want(logic [7:0] b, logic last, logic [1:0] st);
		plan_row_t r;
		r = read_row();
		r.typed = 1'b1;
		r.want = '{out_byte: b, last_out: last, status: st};
		return r;
	endfunction

	// hold the sender off until every expected result has come back
	task automatic wait_for_results();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_for_results();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ROWS:    cfg_rows = val;
			REG_COLS:    cfg_cols = val;
			REG_REVERSE: cfg_reverse = val[0];
			default:     ;
		endcase
		n_writes++;
	endtask

	// one transaction; expectation queued at acceptance
	task automatic send_item(logic op, logic [7:0] din, logic typed = 1'b0,
		result_t want = '0);
		int gap;
		result_t predicted;
		gap = pick_wait(send_calm);
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.opcode = op;
		item_ch.data_byte = din;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		predicted = next_interleaver_result(op, din);
		pending_results.push_back(typed ? want : predicted);
		n_items++;
	endtask

	// random phase: a matrix shape, then whole blocks with wrong-phase noise
	task automatic run_random_phase();
		int rows;
		int cols;
		int size;
		int blocks;
		int pick;
		pick = $urandom_range(0, 11);
		if (pick == 0) begin
			// empty or oversize matrix: everything is refused
			case ($urandom_range(0, 2))
				0: begin
					rows = 0;
					cols = $urandom_range(0, 511);
				end
				1: begin
					rows = $urandom_range(1, 511);
					cols = 0;
				end
				default: begin
					rows = $urandom_range(257, 511);
					cols = $urandom_range(256, 511);
				end
			endcase
			write_reg(REG_ROWS, CFG_W'(rows));
			write_reg(REG_COLS, CFG_W'(cols));
			repeat ($urandom_range(2, 5))
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			return;
		end
		case (pick)
			1: begin
				rows = 1;
				cols = 128;
			end
			2: begin
				rows = 128;
				cols = 1;
			end
			3: begin
				rows = 1;
				cols = 1;
			end
			4: begin
				rows = 8;
				cols = 16;
			end
			default: begin
				rows = $urandom_range(1, 12);
				cols = $urandom_range(1, 12);
			end
		endcase
		size = rows * cols;
		blocks = (size > 64) ? 1 : $urandom_range(1, 3);
		// keep the run near its transaction budget
		if (2 * blocks * size > RANDOM_ITEMS - random_count) begin
			rows = $urandom_range(1, 4);
			cols = $urandom_range(1, 4);
			size = rows * cols;
			blocks = 1;
		end
		if ($urandom_range(0, 1)) begin
			write_reg(REG_ROWS, CFG_W'(rows));
			write_reg(REG_COLS, CFG_W'(cols));
		end else begin
			write_reg(REG_COLS, CFG_W'(cols));
			write_reg(REG_ROWS, CFG_W'(rows));
		end
		// upper data bits of the mode register are don't-care
		write_reg(REG_REVERSE, CFG_W'($urandom_range(0, 511)));
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_NONE, CFG_W'($urandom_range(0, 511)));
		repeat (blocks) begin
			for (int i = 0; i < size; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_item(OP_READ, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 99) == 0)
					wait_for_results();
				send_item(OP_LOAD, 8'($urandom_range(0, 255)));
				random_count++;
			end
			for (int i = 0; i < size; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_item(OP_LOAD, 8'($urandom_range(0, 255)));
				send_item(OP_READ, 8'($urandom_range(0, 255)));
				random_count++;
			end
		end
	endtask

	// result side: random stalls on ready
	initial begin : result_taker
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			stall = pick_wait(take_calm);
			@(negedge clk);
			if (stall != 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (result_ch.valid !== 1'b1);
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			n_results++;
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: result with nothing expected: byte %0h last %0b status %0d",
					$time, result_ch.out_byte, result_ch.last_out, result_ch.status);
			end else begin
				want = pending_results.pop_front();
				if (want.status == STAT_REFUSED)
					n_refused++;
				if (want.status == STAT_READ && want.last_out)
					n_blocks++;
				if (result_ch.out_byte !== want.out_byte) begin
					err_count++;
					$display("%0t: out_byte expected %0h actual %0h",
						$time, want.out_byte, result_ch.out_byte);
				end
				if (result_ch.last_out !== want.last_out) begin
					err_count++;
					$display("%0t: last_out expected %0b actual %0b",
						$time, want.last_out, result_ch.last_out);
				end
				if (result_ch.status !== want.status) begin
					err_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result_ch.status);
				end
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// stimulus
	initial begin
		plan = '{
			// reset shape is 1x1
			read_row_want(8'h00, 1'b0, STAT_REFUSED),
			load_row_want(8'hFF, STAT_LOADED),
			load_row_want(8'h00, STAT_REFUSED),
			read_row_want(8'hFF, 1'b1, STAT_READ),
			// 2x2 forward, upper mode bits set but bit 0 clear
			cfg_row(REG_ROWS, 9'd2),
			cfg_row(REG_COLS, 9'd2),
			cfg_row(REG_REVERSE, 9'h1FE),
			load_row(8'h00), load_row(8'h80), load_row(8'h7F), load_row(8'h01),
			read_row(), read_row(),
			// shrink while draining: pointer saturates on the last cell
			cfg_row(REG_COLS, 9'd1),
			read_row(),
			cfg_row(REG_COLS, 9'd2),
			load_row(8'hAA),
			// shrink while loading: scatter pointer past the end restarts at 0
			cfg_row(REG_COLS, 9'd1),
			cfg_row(REG_REVERSE, 9'h1FF),
			load_row(8'h55),
			read_row(), read_row(),
			// 2x2 reverse, then shrink so the fill count is already past size
			cfg_row(REG_COLS, 9'd2),
			load_row(8'h12), load_row(8'h34), load_row(8'h56),
			cfg_row(REG_COLS, 9'd1),
			load_row(8'h78),
			read_row(), read_row(),
			// empty matrix
			cfg_row(REG_ROWS, 9'd0),
			load_row_want(8'hC3, STAT_REFUSED),
			// oversize matrix, then a write to an unused index
			cfg_row(REG_ROWS, 9'h1FF),
			cfg_row(REG_COLS, 9'h1FF),
			read_row_want(8'h00, 1'b0, STAT_REFUSED),
			cfg_row(REG_NONE, 9'h1FF),
			load_row_want(8'h3C, STAT_REFUSED),
			// largest legal matrix, one load, then back to 1x1
			cfg_row(REG_ROWS, 9'd256),
			cfg_row(REG_COLS, 9'd256),
			load_row(8'h5A),
			cfg_row(REG_ROWS, 9'd1),
			cfg_row(REG_COLS, 9'd1),
			cfg_row(REG_REVERSE, 9'd0),
			load_row(8'hA5),
			read_row()
		};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_LOAD;
		item_ch.data_byte = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].val);
			else
				send_item(plan[i].op, plan[i].din, plan[i].typed, plan[i].want);
		end

		// random blocks
		while (random_count < RANDOM_ITEMS)
			run_random_phase();

		wait_for_results();
		repeat (12) @(posedge clk);

		$display("Ran %0d transactions and %0d register writes; %0d results checked,",
			n_items, n_writes, n_results);
		$display("%0d full blocks drained, %0d refused requests, %0d mismatches",
			n_blocks, n_refused, err_count);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/bi_pkg.sv
rtl/bi_in_if.sv
rtl/bi_out_if.sv
rtl/bi_ctrl.sv
rtl/bi_dp.sv
rtl/block_interleaver_top.sv
tb/sv/block_interleaver_top_tb.sv
